>>> hdl/assert_macros.svh
// Assertion macros used by the block's top-level RTL.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/mi_pkg.sv
// Shared types and constants of the 4x4 matrix inverse block.
// No dependencies.
package mi_pkg;
    localparam int ELEM_W           = 32;
    localparam int IDX_W            = 4;
    localparam int N_ELEM           = 16;
    localparam int ACC_W            = 136;
    localparam int OUT_W            = 64;
    localparam int OUT_FRAC_BITS    = 32;
    localparam int QUEUE_DEPTH      = 4;
    localparam int IN_FRAC_BITS_DEF = 16;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(N_ELEM - 1);

    typedef struct packed {
        logic [IDX_W-1:0]  idx;
        logic [ELEM_W-1:0] value;
    } t_elem_req;
endpackage

>>> hdl/mi_front.sv
// Front end: numbers incoming element requests and hands them to the queue.
// Depends on mi_pkg.
module mi_front import mi_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic              i_full,
    input  logic [ELEM_W-1:0] i_elem_value,
    output logic              o_push,
    output t_elem_req         o_req
);
    logic [IDX_W-1:0] r_count;

    assign o_push      = i_start && !i_full;
    assign o_req.idx   = r_count;
    assign o_req.value = i_elem_value;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (o_push) begin
            r_count <= r_count + 1'b1;
        end
    end
endmodule

>>> hdl/mi_queue.sv
// Short request queue between front and back ends.
// Depends on mi_pkg.
module mi_queue import mi_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_elem_req i_push_req,
    output logic      o_full,
    input  logic      i_pop,
    output logic      o_valid,
    output t_elem_req o_head
);
    localparam int PTR_W = $clog2(DEPTH);

    t_elem_req        r_slot [DEPTH];
    logic [PTR_W:0]   r_wr_ptr;
    logic [PTR_W:0]   r_rd_ptr;

    assign o_valid = r_wr_ptr != r_rd_ptr;
    assign o_full  = (r_wr_ptr[PTR_W] != r_rd_ptr[PTR_W]) &&
                     (r_wr_ptr[PTR_W-1:0] == r_rd_ptr[PTR_W-1:0]);
    assign o_head  = r_slot[r_rd_ptr[PTR_W-1:0]];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop && o_valid) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr[PTR_W-1:0]] <= i_push_req;
        end
    end
endmodule

>>> hdl/mi_back.sv
// Back end: matrix store, bit-serial cofactor/determinant MAC sequencer and
// restoring divider with saturation. Depends on mi_pkg.
module mi_back import mi_pkg::*; #(
    parameter int IN_FRAC_BITS = IN_FRAC_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_req_valid,
    input  t_elem_req        i_req,
    output logic             o_pop,
    output logic             o_result_valid,
    output logic [OUT_W-1:0] o_inv_value,
    output logic             o_singular,
    output logic             o_last
);
    localparam int NUM_W  = ACC_W + IN_FRAC_BITS + OUT_FRAC_BITS;
    localparam int DCNT_W = $clog2(NUM_W);
    localparam int K_W    = $clog2(ELEM_W);
    localparam logic [K_W-1:0]    K_LAST = K_W'(ELEM_W - 1);
    localparam logic [DCNT_W-1:0] D_LAST = DCNT_W'(NUM_W - 1);

    localparam logic [2:0] S_LOAD   = 3'd0;
    localparam logic [2:0] S_FETCH  = 3'd1;
    localparam logic [2:0] S_SETUP  = 3'd2;
    localparam logic [2:0] S_MUL    = 3'd3;
    localparam logic [2:0] S_CHECK  = 3'd4;
    localparam logic [2:0] S_RDADJ  = 3'd5;
    localparam logic [2:0] S_DSETUP = 3'd6;
    localparam logic [2:0] S_DSTEP  = 3'd7;

    localparam logic [3:0] ST_PP1  = 4'd0;
    localparam logic [3:0] ST_PM1  = 4'd1;
    localparam logic [3:0] ST_ACC1 = 4'd2;
    localparam logic [3:0] ST_PP2  = 4'd3;
    localparam logic [3:0] ST_PM2  = 4'd4;
    localparam logic [3:0] ST_ACC2 = 4'd5;
    localparam logic [3:0] ST_PP3  = 4'd6;
    localparam logic [3:0] ST_PM3  = 4'd7;
    localparam logic [3:0] ST_ACC3 = 4'd8;
    localparam logic [3:0] ST_DET  = 4'd9;

    localparam logic [OUT_W-1:0] SAT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic [OUT_W-1:0] SAT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

    logic [ELEM_W-1:0] r_mem [N_ELEM];
    logic [ACC_W-1:0]  r_adj [N_ELEM];

    logic [2:0]        r_state;
    logic [3:0]        r_step;
    logic [IDX_W-1:0]  r_cof;
    logic [K_W-1:0]    r_k;
    logic [DCNT_W-1:0] r_dcnt;
    logic [ELEM_W-1:0] r_rd_a, r_rd_b, r_a;
    logic [ACC_W-1:0]  r_bsh, r_t, r_acc, r_det, r_den, r_adj_rd, r_rem;
    logic [NUM_W-1:0]  r_num;
    logic [OUT_W-1:0]  r_q;
    logic              r_ovf, r_neg;
    logic              r_out_valid, r_out_sing, r_out_last;
    logic [OUT_W-1:0]  r_out_value;

    function automatic logic [1:0] skip(input logic [1:0] x, input logic [1:0] n);
        return (n >= x) ? n + 2'd1 : n;
    endfunction

    function automatic logic [ACC_W-1:0] sext(input logic [ELEM_W-1:0] v);
        return {{(ACC_W-ELEM_W){v[ELEM_W-1]}}, v};
    endfunction

    function automatic logic [ACC_W-1:0] mag(input logic [ACC_W-1:0] v);
        return v[ACC_W-1] ? -v : v;
    endfunction

    logic [1:0] xr, xc, r0, r1, r2, c0, c1, c2;
    logic       odd;
    logic [IDX_W-1:0] addr_a, addr_b;
    logic       op_clr, op_sub;
    logic [1:0] op_tgt;
    logic [ACC_W-1:0] tgt_val, partial, base, mac_res;
    logic       sub_eff;

    assign xr  = r_cof[3:2];
    assign xc  = r_cof[1:0];
    assign odd = xr[0] ^ xc[0];
    assign r0  = skip(xr, 2'd0);
    assign r1  = skip(xr, 2'd1);
    assign r2  = skip(xr, 2'd2);
    assign c0  = skip(xc, 2'd0);
    assign c1  = skip(xc, 2'd1);
    assign c2  = skip(xc, 2'd2);

    always_comb begin
        addr_a = '0;
        addr_b = '0;
        op_clr = 1'b0;
        op_sub = 1'b0;
        op_tgt = 2'd0;
        case (r_step)
            ST_PP1: begin
                addr_a = {r1, c1}; addr_b = {r2, c2}; op_clr = 1'b1;
            end
            ST_PM1: begin
                addr_a = {r1, c2}; addr_b = {r2, c1}; op_sub = 1'b1;
            end
            ST_ACC1: begin
                addr_a = {r0, c0}; op_clr = 1'b1; op_sub = odd; op_tgt = 2'd1;
            end
            ST_PP2: begin
                addr_a = {r1, c0}; addr_b = {r2, c2}; op_clr = 1'b1;
            end
            ST_PM2: begin
                addr_a = {r1, c2}; addr_b = {r2, c0}; op_sub = 1'b1;
            end
            ST_ACC2: begin
                addr_a = {r0, c1}; op_sub = !odd; op_tgt = 2'd1;
            end
            ST_PP3: begin
                addr_a = {r1, c0}; addr_b = {r2, c1}; op_clr = 1'b1;
            end
            ST_PM3: begin
                addr_a = {r1, c1}; addr_b = {r2, c0}; op_sub = 1'b1;
            end
            ST_ACC3: begin
                addr_a = {r0, c2}; op_sub = odd; op_tgt = 2'd1;
            end
            ST_DET: begin
                addr_a = {2'd0, xc}; op_tgt = 2'd2;
            end
            default: begin
                addr_a = '0;
            end
        endcase
    end

    always_comb begin
        case (op_tgt)
            2'd1:    tgt_val = r_acc;
            2'd2:    tgt_val = r_det;
            default: tgt_val = r_t;
        endcase
        partial = r_a[r_k] ? r_bsh : '0;
        sub_eff = op_sub ^ (r_k == K_LAST);
        base    = (op_clr && r_k == '0) ? '0 : tgt_val;
        mac_res = sub_eff ? base - partial : base + partial;
    end

    logic [ACC_W:0]   rem_sh, rem_diff;
    logic             ge;
    logic [OUT_W-1:0] q_new, sat;
    logic             ovf_new;

    always_comb begin
        rem_sh   = {r_rem, r_num[NUM_W-1]};
        rem_diff = rem_sh - {1'b0, r_den};
        ge       = !rem_diff[ACC_W];
        q_new    = {r_q[OUT_W-2:0], ge};
        ovf_new  = r_ovf | r_q[OUT_W-1];
        if (!r_neg) begin
            sat = (ovf_new || q_new[OUT_W-1]) ? SAT_MAX : q_new;
        end else begin
            sat = (ovf_new || q_new > SAT_MIN) ? SAT_MIN : -q_new;
        end
    end

    assign o_pop          = (r_state == S_LOAD) && i_req_valid;
    assign o_result_valid = r_out_valid;
    assign o_inv_value    = r_out_value;
    assign o_singular     = r_out_sing;
    assign o_last         = r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_step      <= ST_PP1;
            r_cof       <= '0;
            r_k         <= '0;
            r_dcnt      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= 1'b0;
            case (r_state)
                S_LOAD: begin
                    if (i_req_valid && i_req.idx == LAST_IDX) begin
                        r_cof   <= '0;
                        r_step  <= ST_PP1;
                        r_state <= S_FETCH;
                    end
                end
                S_FETCH: r_state <= S_SETUP;
                S_SETUP: begin
                    r_k     <= '0;
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_k <= r_k + 1'b1;
                    if (r_k == K_LAST) begin
                        r_state <= S_FETCH;
                        if ((r_step == ST_ACC3 && xr != 2'd0) || r_step == ST_DET) begin
                            r_step <= ST_PP1;
                            if (r_cof == LAST_IDX) begin
                                r_state <= S_CHECK;
                            end else begin
                                r_cof <= r_cof + 1'b1;
                            end
                        end else begin
                            r_step <= r_step + 4'd1;
                        end
                    end
                end
                S_CHECK: begin
                    r_cof <= '0;
                    if (r_det == '0) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_LOAD;
                    end else begin
                        r_state <= S_RDADJ;
                    end
                end
                S_RDADJ:  r_state <= S_DSETUP;
                S_DSETUP: begin
                    r_dcnt  <= '0;
                    r_state <= S_DSTEP;
                end
                S_DSTEP: begin
                    r_dcnt <= r_dcnt + 1'b1;
                    if (r_dcnt == D_LAST) begin
                        r_out_valid <= 1'b1;
                        if (r_cof == LAST_IDX) begin
                            r_state <= S_LOAD;
                        end else begin
                            r_cof   <= r_cof + 1'b1;
                            r_state <= S_RDADJ;
                        end
                    end
                end
                default: r_state <= S_LOAD;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_LOAD: begin
                if (i_req_valid) begin
                    r_mem[i_req.idx] <= i_req.value;
                end
                r_det <= '0;
            end
            S_FETCH: begin
                r_rd_a <= r_mem[addr_a];
                r_rd_b <= r_mem[addr_b];
            end
            S_SETUP: begin
                r_a <= r_rd_a;
                case (op_tgt)
                    2'd1:    r_bsh <= r_t;
                    2'd2:    r_bsh <= r_acc;
                    default: r_bsh <= sext(r_rd_b);
                endcase
            end
            S_MUL: begin
                r_bsh <= r_bsh << 1;
                case (op_tgt)
                    2'd1:    r_acc <= mac_res;
                    2'd2:    r_det <= mac_res;
                    default: r_t   <= mac_res;
                endcase
                if (r_k == K_LAST && r_step == ST_ACC3) begin
                    r_adj[{xc, xr}] <= mac_res;
                end
            end
            S_CHECK: begin
                r_den       <= mag(r_det);
                r_out_value <= '0;
                r_out_sing  <= 1'b1;
                r_out_last  <= 1'b1;
            end
            S_RDADJ: r_adj_rd <= r_adj[r_cof];
            S_DSETUP: begin
                r_neg <= r_adj_rd[ACC_W-1] ^ r_det[ACC_W-1];
                r_num <= {mag(r_adj_rd), {(IN_FRAC_BITS + OUT_FRAC_BITS){1'b0}}};
                r_rem <= '0;
                r_q   <= '0;
                r_ovf <= 1'b0;
            end
            S_DSTEP: begin
                r_rem <= ge ? rem_diff[ACC_W-1:0] : rem_sh[ACC_W-1:0];
                r_num <= r_num << 1;
                r_q   <= q_new;
                r_ovf <= ovf_new;
                if (r_dcnt == D_LAST) begin
                    r_out_value <= sat;
                    r_out_sing  <= 1'b0;
                    r_out_last  <= r_cof == LAST_IDX;
                end
            end
            default: r_a <= r_a;
        endcase
    end
endmodule

>>> hdl/matrix4x4_inverse.sv
// 4x4 matrix inverse by cofactors and adjugate: top level.
// Depends on mi_pkg, mi_front, mi_queue, mi_back and assert_macros.svh.
//
// Elements arrive one request per cycle (start while busy is low), row-major,
// signed Q(32-F).F. Sixteen elements make one matrix. The back end forms each
// of the 148 exact products with one bit-serial multiply-accumulate unit,
// then divides the 16 cofactors one at a time with a restoring divider of
// 136+F+32 steps, each divide preceded by the S_RDADJ and S_DSETUP states.
// Results appear for one cycle each on o_result_valid and cannot be stalled;
// a singular matrix gives one result with o_singular and o_last set. A
// four-deep request queue lets up to four of the next matrix's elements be
// taken while the current one is worked on; busy rises when it is full.
`include "assert_macros.svh"
module matrix4x4_inverse import mi_pkg::*; #(
    parameter int IN_FRAC_BITS = IN_FRAC_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [ELEM_W-1:0] i_elem_value,
    output logic              o_result_valid,
    output logic [OUT_W-1:0]  o_inv_value,
    output logic              o_singular,
    output logic              o_last
);
    logic      push, pop, q_valid;
    t_elem_req push_req, head;

    mi_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_full       (busy),
        .i_elem_value (i_elem_value),
        .o_push       (push),
        .o_req        (push_req)
    );

    mi_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_push_req (push_req),
        .o_full     (busy),
        .i_pop      (pop),
        .o_valid    (q_valid),
        .o_head     (head)
    );

    mi_back #(.IN_FRAC_BITS(IN_FRAC_BITS)) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_req_valid    (q_valid),
        .i_req          (head),
        .o_pop          (pop),
        .o_result_valid (o_result_valid),
        .o_inv_value    (o_inv_value),
        .o_singular     (o_singular),
        .o_last         (o_last)
    );

    `ASSERT_IMP(a_sing_last, i_clk, i_rst_n, o_result_valid && o_singular, o_last && o_inv_value == '0, "singular result must be last and zero")
    `ASSERT_NXT(a_last_gap, i_clk, i_rst_n, o_result_valid && o_last, !o_result_valid, "result directly after last")
    `ASSERT_IMP(a_pop_valid, i_clk, i_rst_n, pop, q_valid, "pop from empty queue")
endmodule

>>> tb/matrix4x4_inverse_tb.sv
// Self-checking testbench for matrix4x4_inverse: feeds whole matrices one element per request.
// Predicts the inverse with exact wide integer arithmetic and checks each result in order.
// Depends on mi_pkg and the matrix4x4_inverse RTL.
module matrix4x4_inverse_tb;
    import mi_pkg::*;

    localparam int FRAC     = IN_FRAC_BITS_DEF;
    localparam int WIDE     = 192;
    localparam int N_RANDOM = 13;

    typedef logic signed [WIDE-1:0] t_wide;

    typedef struct {
        logic [OUT_W-1:0] inv;
        logic             sing;
        logic             last;
    } t_inverse;

    logic              i_clk;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    logic [ELEM_W-1:0] i_elem_value;
    logic              o_result_valid;
    logic [OUT_W-1:0]  o_inv_value;
    logic              o_singular;
    logic              o_last;

    matrix4x4_inverse i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_elem_value   (i_elem_value),
        .o_result_valid (o_result_valid),
        .o_inv_value    (o_inv_value),
        .o_singular     (o_singular),
        .o_last         (o_last)
    );

    logic [ELEM_W-1:0] pending_elems[$];
    logic              pending_hold[$];
    t_inverse          expected_inv[$];
    logic [ELEM_W-1:0] held_matrix[16];
    int                elem_idx;
    int                gap_left;
    int                fail_count;
    int                n_results;
    int                n_singular;
    int                n_saturated;
    int                n_matrices;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_wide elem_at(input int r, input int c);
        logic signed [ELEM_W-1:0] v;
        v = held_matrix[4*r + c];
        return t_wide'(v);
    endfunction

    function automatic t_wide cofactor_of(input int xr, input int xc);
        int    rs[3];
        int    cs[3];
        int    n;
        int    m;
        t_wide acc;
        n = 0;
        m = 0;
        for (int i = 0; i < 4; i++) begin
            if (i != xr) begin
                rs[n] = i;
                n++;
            end
            if (i != xc) begin
                cs[m] = i;
                m++;
            end
        end
        acc = elem_at(rs[0], cs[0]) * (elem_at(rs[1], cs[1]) * elem_at(rs[2], cs[2])
                                     - elem_at(rs[1], cs[2]) * elem_at(rs[2], cs[1]))
            - elem_at(rs[0], cs[1]) * (elem_at(rs[1], cs[0]) * elem_at(rs[2], cs[2])
                                     - elem_at(rs[1], cs[2]) * elem_at(rs[2], cs[0]))
            + elem_at(rs[0], cs[2]) * (elem_at(rs[1], cs[0]) * elem_at(rs[2], cs[1])
                                     - elem_at(rs[1], cs[1]) * elem_at(rs[2], cs[0]));
        return ((xr + xc) % 2 != 0) ? -acc : acc;
    endfunction

    task automatic predict_inverse();
        t_wide           adj[16];
        t_wide           det;
        logic [WIDE-1:0] num;
        logic [WIDE-1:0] den;
        logic [WIDE-1:0] quo;
        bit              neg;
        t_inverse        r;
        det = '0;
        for (int i = 0; i < 4; i++)
            for (int j = 0; j < 4; j++)
                adj[4*j + i] = cofactor_of(i, j);
        for (int j = 0; j < 4; j++)
            det += elem_at(0, j) * adj[4*j];
        n_matrices++;
        if (det == 0) begin
            r.inv  = '0;
            r.sing = 1'b1;
            r.last = 1'b1;
            expected_inv.push_back(r);
            n_singular++;
            return;
        end
        for (int i = 0; i < 16; i++) begin
            neg = (adj[i] < 0) != (det < 0);
            num = (adj[i] < 0) ? -adj[i] : adj[i];
            den = (det < 0) ? -det : det;
            num = num << (FRAC + OUT_FRAC_BITS);
            quo = num / den;
            r.sing = 1'b0;
            r.last = (i == 15);
            if (!neg && quo > {1'b0, {(OUT_W-1){1'b1}}}) begin
                r.inv = {1'b0, {(OUT_W-1){1'b1}}};
                n_saturated++;
            end else if (neg && quo > {1'b1, {(OUT_W-1){1'b0}}}) begin
                r.inv = {1'b1, {(OUT_W-1){1'b0}}};
                n_saturated++;
            end else begin
                r.inv = neg ? -quo[OUT_W-1:0] : quo[OUT_W-1:0];
            end
            expected_inv.push_back(r);
        end
    endtask

    task automatic queue_matrix(input int kind, input bit hold);
        logic [ELEM_W-1:0] m[16];
        for (int k = 0; k < 16; k++) begin
            case (kind)
                0: m[k] = $urandom;
                1: m[k] = ELEM_W'($signed($urandom_range(0, 8 << FRAC)) - (4 << FRAC));
                2: m[k] = ($urandom_range(0, 1) != 0) ? 32'h7fff_ffff : 32'h8000_0000;
                3: m[k] = (k % 5 == 0) ? 32'd1 : ((k % 4 > k / 4) ? $urandom : 32'd0);
                default: m[k] = $urandom_range(0, 3) << FRAC;
            endcase
        end
        if (kind == 4) begin
            for (int c = 0; c < 4; c++)
                m[8 + c] = m[4 + c];
        end
        for (int k = 0; k < 16; k++) begin
            pending_elems.push_back(m[k]);
            pending_hold.push_back(hold && k == 0);
        end
    endtask

    initial begin
        for (int k = 0; k < 16; k++)
            pending_elems.push_back((k % 5 == 0) ? 32'(1 << FRAC) : 32'd0);
        for (int k = 0; k < 16; k++) begin
            pending_elems.push_back(32'd0);
            pending_hold.push_back(1'b0);
            pending_hold.push_back(1'b0);
        end
        queue_matrix(3, 1'b0);
        queue_matrix(2, 1'b1);
        for (int n = 0; n < N_RANDOM; n++)
            queue_matrix($urandom_range(0, 4), n == N_RANDOM / 2);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start        <= 1'b0;
            i_elem_value <= '0;
            elem_idx     <= 0;
            gap_left     <= 0;
        end else begin
            if (start && !busy) begin
                held_matrix[elem_idx] = i_elem_value;
                if (elem_idx == 15)
                    predict_inverse();
                elem_idx <= (elem_idx + 1) % 16;
                void'(pending_elems.pop_front());
                void'(pending_hold.pop_front());
            end
            if (start && busy) begin
                start <= 1'b1;
            end else if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                start    <= 1'b0;
            end else if (pending_elems.size() == 0) begin
                start <= 1'b0;
            end else if (pending_hold[0] && expected_inv.size() != 0) begin
                start <= 1'b0;
            end else if (pending_elems.size() > 48 && $urandom_range(0, 7) == 0) begin
                gap_left <= $urandom_range(0, 11);
                start    <= 1'b0;
            end else begin
                start        <= 1'b1;
                i_elem_value <= pending_elems[0];
            end
        end
    end

    always @(posedge i_clk) begin
        t_inverse e;
        if (i_rst_n && o_result_valid) begin
            n_results++;
            if (expected_inv.size() == 0) begin
                $display("%0t: unexpected result inv=%h singular=%b last=%b",
                         $time, o_inv_value, o_singular, o_last);
                fail_count++;
            end else begin
                e = expected_inv.pop_front();
                if (o_inv_value !== e.inv) begin
                    $display("%0t: inv_value expected %h actual %h", $time, e.inv, o_inv_value);
                    fail_count++;
                end
                if (o_singular !== e.sing) begin
                    $display("%0t: singular expected %b actual %b", $time, e.sing, o_singular);
                    fail_count++;
                end
                if (o_last !== e.last) begin
                    $display("%0t: last expected %b actual %b", $time, e.last, o_last);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        i_rst_n = 1'b0;
        start = 1'b0;
        i_elem_value = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        wait (pending_elems.size() == 0);
        @(posedge i_clk);
        wait (expected_inv.size() == 0);
        repeat (200) @(posedge i_clk);
        $display("Covered %0d matrices: %0d results, %0d singular, %0d saturated elements.",
                 n_matrices, n_results, n_singular, n_saturated);
        if (fail_count == 0 && expected_inv.size() == 0)
            $display("matrix4x4_inverse test passed");
        else
            $display("matrix4x4_inverse test failed");
        $finish;
    end

    initial begin
        #30_000_000;
        $display("Timed out with %0d results outstanding.", expected_inv.size());
        $display("matrix4x4_inverse test failed");
        $finish;
    end
endmodule
